>>> rtl/ple_pkg.sv
// Shared constants, command codes and status types for the positional list engine.
package ple_pkg;

	localparam int CAPACITY = 64;
	localparam int ADDR_W   = $clog2(CAPACITY);
	localparam int DATA_W   = 32;
	localparam int POS_W    = 7;
	localparam int MODE_W   = 2;

	localparam logic [MODE_W-1:0] MODE_GET    = 2'd0;
	localparam logic [MODE_W-1:0] MODE_INSERT = 2'd1;
	localparam logic [MODE_W-1:0] MODE_DELETE = 2'd2;

	typedef enum logic [2:0] {
		CMD_NONE,
		CMD_LOAD,
		CMD_READ_POS,
		CMD_CAPTURE,
		CMD_READ_SHIFT,
		CMD_WRITE_SHIFT,
		CMD_WRITE_VAL,
		CMD_COMMIT
	} ple_cmd_t;

	typedef struct packed {
		logic err;
		logic is_insert;
		logic is_get;
		logic more;
	} ple_sts_t;

endpackage

>>> rtl/ple_if.sv
// Request and response channel interfaces for the positional list engine.
interface ple_req_if;
	logic                              valid;
	logic                              ready;
	logic        [ple_pkg::MODE_W-1:0] mode;
	logic        [ple_pkg::POS_W-1:0]  position;
	logic signed [ple_pkg::DATA_W-1:0] value;

	modport source (output valid, output mode, output position, output value, input ready);
	modport sink (input valid, input mode, input position, input value, output ready);
endinterface

interface ple_rsp_if;
	logic                              valid;
	logic                              ready;
	logic                              status;
	logic signed [ple_pkg::DATA_W-1:0] element;
	logic        [ple_pkg::POS_W-1:0]  count;

	modport source (output valid, output status, output element, output count, input ready);
	modport sink (input valid, input status, input element, input count, output ready);
endinterface

>>> rtl/ple_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ple_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> rtl/ple_datapath.sv
// Datapath: element RAM, length, shift cursor, request capture and response register.
module ple_datapath (
	input  logic                              clk,
	input  logic                              arst_n,
	input  ple_pkg::ple_cmd_t                 cmd,
	output ple_pkg::ple_sts_t                 sts,
	input  logic        [ple_pkg::MODE_W-1:0] in_mode,
	input  logic        [ple_pkg::POS_W-1:0]  in_position,
	input  logic signed [ple_pkg::DATA_W-1:0] in_value,
	output logic                              out_status,
	output logic signed [ple_pkg::DATA_W-1:0] out_element,
	output logic        [ple_pkg::POS_W-1:0]  out_count
);

	logic        [ple_pkg::MODE_W-1:0] mode_q;
	logic        [ple_pkg::POS_W-1:0]  pos_q;
	logic signed [ple_pkg::DATA_W-1:0] val_q;
	logic                              err_q;
	logic        [ple_pkg::ADDR_W-1:0] cur_q;
	logic        [ple_pkg::DATA_W-1:0] elem_q;
	logic        [ple_pkg::POS_W-1:0]  len_q;

	logic                              req_ok;
	logic        [ple_pkg::POS_W-1:0]  in_pos_m1;
	logic        [ple_pkg::POS_W-1:0]  pos_m1;
	logic        [ple_pkg::POS_W-1:0]  len_next;
	logic                              is_insert;
	logic                              we;
	logic        [ple_pkg::ADDR_W-1:0] waddr;
	logic        [ple_pkg::DATA_W-1:0] wdata;
	logic                              re;
	logic        [ple_pkg::ADDR_W-1:0] raddr;
	logic        [ple_pkg::DATA_W-1:0] rdata;

	assign is_insert = (mode_q == ple_pkg::MODE_INSERT);
	assign in_pos_m1 = in_position - ple_pkg::POS_W'(1);
	assign pos_m1    = pos_q - ple_pkg::POS_W'(1);

	always_comb begin
		req_ok = 1'b0;
		if (in_position != '0) begin
			if (in_mode == ple_pkg::MODE_GET || in_mode == ple_pkg::MODE_DELETE) begin
				req_ok = (in_position <= len_q);
			end else if (in_mode == ple_pkg::MODE_INSERT) begin
				req_ok = ({1'b0, in_position} <= ({1'b0, len_q} + (ple_pkg::POS_W+1)'(1)))
					&& (len_q < ple_pkg::POS_W'(ple_pkg::CAPACITY));
			end
		end
	end

	always_comb begin
		sts.err       = err_q;
		sts.is_insert = is_insert;
		sts.is_get    = (mode_q == ple_pkg::MODE_GET);
		if (is_insert) begin
			sts.more = ({1'b0, cur_q} >= pos_q);
		end else begin
			sts.more = (({1'b0, cur_q} + ple_pkg::POS_W'(1)) < len_q);
		end
	end

	always_comb begin
		len_next = len_q;
		if (!err_q) begin
			if (mode_q == ple_pkg::MODE_INSERT) begin
				len_next = len_q + ple_pkg::POS_W'(1);
			end else if (mode_q == ple_pkg::MODE_DELETE) begin
				len_next = len_q - ple_pkg::POS_W'(1);
			end
		end
	end

	always_comb begin
		re    = 1'b0;
		raddr = pos_m1[ple_pkg::ADDR_W-1:0];
		we    = 1'b0;
		waddr = cur_q;
		wdata = rdata;
		unique case (cmd)
			ple_pkg::CMD_READ_POS: begin
				re = 1'b1;
			end
			ple_pkg::CMD_READ_SHIFT: begin
				re    = 1'b1;
				raddr = is_insert ? (cur_q - ple_pkg::ADDR_W'(1)) : (cur_q + ple_pkg::ADDR_W'(1));
			end
			ple_pkg::CMD_WRITE_SHIFT: begin
				we = 1'b1;
			end
			ple_pkg::CMD_WRITE_VAL: begin
				we    = 1'b1;
				waddr = pos_m1[ple_pkg::ADDR_W-1:0];
				wdata = val_q;
			end
			default: begin
			end
		endcase
	end

	ple_ram #(
		.WIDTH (ple_pkg::DATA_W),
		.DEPTH (ple_pkg::CAPACITY)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (re),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= '0;
		end else if (cmd == ple_pkg::CMD_COMMIT) begin
			len_q <= len_next;
		end
	end

	always_ff @(posedge clk) begin
		unique case (cmd)
			ple_pkg::CMD_LOAD: begin
				mode_q <= in_mode;
				pos_q  <= in_position;
				val_q  <= in_value;
				err_q  <= !req_ok;
				cur_q  <= (in_mode == ple_pkg::MODE_INSERT) ? len_q[ple_pkg::ADDR_W-1:0]
					: in_pos_m1[ple_pkg::ADDR_W-1:0];
			end
			ple_pkg::CMD_CAPTURE: begin
				elem_q <= rdata;
			end
			ple_pkg::CMD_WRITE_SHIFT: begin
				cur_q <= is_insert ? (cur_q - ple_pkg::ADDR_W'(1)) : (cur_q + ple_pkg::ADDR_W'(1));
			end
			ple_pkg::CMD_COMMIT: begin
				out_status  <= err_q;
				out_element <= (err_q || is_insert) ? '0 : elem_q;
				out_count   <= len_next;
			end
			default: begin
			end
		endcase
	end

endmodule

>>> rtl/ple_ctrl.sv
// Controller: sequences each transaction through the datapath and owns both handshakes.
module ple_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	output ple_pkg::ple_cmd_t cmd,
	input  ple_pkg::ple_sts_t sts
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_DISPATCH,
		S_WAIT_POS,
		S_SH_CHK,
		S_SH_WR,
		S_FIN
	} state_t;

	state_t state_q;
	state_t state_nxt;
	logic   out_vld_q;
	logic   out_free;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_vld_q;
	assign out_free  = !out_vld_q || out_ready;

	always_comb begin
		cmd       = ple_pkg::CMD_NONE;
		state_nxt = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd       = ple_pkg::CMD_LOAD;
					state_nxt = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				priority if (sts.err) begin
					state_nxt = S_FIN;
				end else if (sts.is_insert) begin
					state_nxt = S_SH_CHK;
				end else begin
					cmd       = ple_pkg::CMD_READ_POS;
					state_nxt = S_WAIT_POS;
				end
			end
			S_WAIT_POS: begin
				cmd       = ple_pkg::CMD_CAPTURE;
				state_nxt = sts.is_get ? S_FIN : S_SH_CHK;
			end
			S_SH_CHK: begin
				priority if (sts.more) begin
					cmd       = ple_pkg::CMD_READ_SHIFT;
					state_nxt = S_SH_WR;
				end else if (sts.is_insert) begin
					cmd       = ple_pkg::CMD_WRITE_VAL;
					state_nxt = S_FIN;
				end else begin
					state_nxt = S_FIN;
				end
			end
			S_SH_WR: begin
				cmd       = ple_pkg::CMD_WRITE_SHIFT;
				state_nxt = S_SH_CHK;
			end
			S_FIN: begin
				if (out_free) begin
					cmd       = ple_pkg::CMD_COMMIT;
					state_nxt = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			out_vld_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd == ple_pkg::CMD_COMMIT) begin
				out_vld_q <= 1'b1;
			end else if (out_ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

endmodule

>>> rtl/positional_list_engine.sv
// Top level of the positional list engine: controller plus datapath.
// Keeps an ordered list of up to 64 signed 32-bit values in a single RAM with one
// write and one registered read port; each request gets exactly one response.
// Each transaction is loaded and dispatched, reads the element at its position for
// get and delete, shifts elements for insert and delete, writes the value for insert,
// and ends with a commit of the response; an erroneous request goes straight to it.
// The shift loop moves one element at a time: a read, then a write on the RAM.
// A finished response waits in an output register, so a new request is taken
// while the previous response is still pending; a transaction that finishes before
// that response is taken holds in its final state until it is.
module positional_list_engine (
	input  logic       clk,
	input  logic       arst_n,
	ple_req_if.sink    req,
	ple_rsp_if.source  rsp
);

	ple_pkg::ple_cmd_t cmd;
	ple_pkg::ple_sts_t sts;

	ple_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	ple_datapath u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.in_mode     (req.mode),
		.in_position (req.position),
		.in_value    (req.value),
		.out_status  (rsp.status),
		.out_element (rsp.element),
		.out_count   (rsp.count)
	);

endmodule
